// ===== rtl/npd_pkg.sv =====
// Package: shared types, constants and command/status structs of the priority dispatcher.
package npd_pkg;

    localparam int TABLE_SLOTS   = 16;
    localparam int PRIORITY_BITS = 8;
    localparam int TIME_BITS     = 32;

    localparam int SLOT_BITS  = $clog2(TABLE_SLOTS);
    localparam int CNT_BITS   = $clog2(TABLE_SLOTS + 1);
    localparam int AGE_BITS   = SLOT_BITS;
    localparam int ID_BITS    = 16;
    localparam int BURST_BITS = 16;
    localparam int TOTAL_BITS = 48;
    localparam int SUM_BITS   = ((TIME_BITS > BURST_BITS) ? TIME_BITS : BURST_BITS) + 1;

    typedef logic [PRIORITY_BITS-1:0] prio_t;
    typedef logic [TIME_BITS-1:0]     time_t;
    typedef logic [BURST_BITS-1:0]    burst_t;
    typedef logic [ID_BITS-1:0]       id_t;
    typedef logic [AGE_BITS-1:0]      age_t;
    typedef logic [SLOT_BITS-1:0]     slot_idx_t;
    typedef logic [CNT_BITS-1:0]      cnt_t;
    typedef logic [TOTAL_BITS-1:0]    total_t;
    typedef logic [SUM_BITS-1:0]      tsum_t;

    localparam cnt_t  SCAN_END   = cnt_t'(TABLE_SLOTS);
    localparam cnt_t  CNT_ONE    = cnt_t'(1);
    localparam tsum_t TIME_LIMIT = tsum_t'({TIME_BITS{1'b1}});

    localparam logic OP_SUBMIT   = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    typedef enum logic [1:0] {
        ST_SUBMITTED  = 2'd0,
        ST_FULL       = 2'd1,
        ST_DISPATCHED = 2'd2,
        ST_EMPTY      = 2'd3
    } status_t;

    typedef struct packed {
        prio_t  prio;
        burst_t burst;
        time_t  arrival;
        id_t    id;
    } slot_t;

    typedef struct packed {
        logic      capture;
        logic      sub_write;
        logic      rd_en;
        slot_idx_t rd_addr;
        logic      pass2;
        logic      scan_clr;
        logic      jump;
        logic      calc1;
        logic      calc2;
        logic      calc3;
        logic      retire;
        logic      emit;
        status_t   emit_status;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic slot_free;
    } stat_t;

endpackage

// ===== rtl/nonpreemptive_priority_dispatcher_top.sv =====
// Top level: nonpreemptive priority dispatcher, controller plus datapath.
// Submit: when full, the result is strobed straight from idle; else a search from slot 0 fills the lowest free slot.
// Dispatch: when empty, the result is strobed straight from idle; else the single-read-port job table
// is read in two sequential passes (earliest arrival, then highest-priority ready job) before the arithmetic.
// One transaction in flight; busy drops in the cycle the result is registered.
// rst_n clears the table, id counter, clock and totals; the receiver cannot stall.
module nonpreemptive_priority_dispatcher_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic [7:0]  job_priority,
    input  logic [15:0] job_burst,
    input  logic [31:0] job_arrival,
    output logic        done,
    output logic [1:0]  status,
    output logic [15:0] job_number,
    output logic [31:0] dispatch_time,
    output logic [31:0] job_wait,
    output logic [31:0] job_turnaround,
    output logic [47:0] sum_wait,
    output logic [47:0] sum_turnaround,
    output logic [15:0] jobs_done,
    output logic        run_finished
);

    npd_pkg::cmd_t  cmd;
    npd_pkg::stat_t stat;

    npd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy)
    );

    npd_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .job_priority   (job_priority),
        .job_burst      (job_burst),
        .job_arrival    (job_arrival),
        .done           (done),
        .status         (status),
        .job_number     (job_number),
        .dispatch_time  (dispatch_time),
        .job_wait       (job_wait),
        .job_turnaround (job_turnaround),
        .sum_wait       (sum_wait),
        .sum_turnaround (sum_turnaround),
        .jobs_done      (jobs_done),
        .run_finished   (run_finished)
    );

endmodule

// ===== rtl/npd_ctrl.sv =====
// Controller: sequences submit slot search, the two dispatch scans and result arithmetic.
module npd_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           opcode,
    input  npd_pkg::stat_t stat,
    output npd_pkg::cmd_t  cmd,
    output logic           busy
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_SUB_FIND = 9'b000000010,
        S_SCAN1    = 9'b000000100,
        S_JUMP     = 9'b000001000,
        S_SCAN2    = 9'b000010000,
        S_CALC1    = 9'b000100000,
        S_CALC2    = 9'b001000000,
        S_CALC3    = 9'b010000000,
        S_RETIRE   = 9'b100000000
    } state_t;

    state_t        state_reg, state_next;
    npd_pkg::cnt_t idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        cmd         = '0;
        cmd.rd_addr = idx_reg[npd_pkg::SLOT_BITS-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    idx_next    = '0;
                    if (opcode == npd_pkg::OP_SUBMIT)
                    begin
                        if (stat.full)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = npd_pkg::ST_FULL;
                        end
                        else
                        begin
                            state_next = S_SUB_FIND;
                        end
                    end
                    else
                    begin
                        if (stat.empty)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = npd_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.scan_clr = 1'b1;
                            state_next   = S_SCAN1;
                        end
                    end
                end
            end
            S_SUB_FIND:
            begin
                if (stat.slot_free)
                begin
                    cmd.sub_write   = 1'b1;
                    cmd.emit        = 1'b1;
                    cmd.emit_status = npd_pkg::ST_SUBMITTED;
                    state_next      = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + npd_pkg::CNT_ONE;
                end
            end
            S_SCAN1, S_SCAN2:
            begin
                cmd.pass2 = (state_reg == S_SCAN2);
                if (idx_reg == npd_pkg::SCAN_END)
                begin
                    idx_next   = '0;
                    state_next = (state_reg == S_SCAN1) ? S_JUMP : S_CALC1;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    idx_next  = idx_reg + npd_pkg::CNT_ONE;
                end
            end
            S_JUMP:
            begin
                cmd.jump   = 1'b1;
                state_next = S_SCAN2;
            end
            S_CALC1:
            begin
                cmd.calc1  = 1'b1;
                state_next = S_CALC2;
            end
            S_CALC2:
            begin
                cmd.calc2  = 1'b1;
                state_next = S_CALC3;
            end
            S_CALC3:
            begin
                cmd.calc3  = 1'b1;
                state_next = S_RETIRE;
            end
            S_RETIRE:
            begin
                cmd.retire      = 1'b1;
                cmd.emit        = 1'b1;
                cmd.emit_status = npd_pkg::ST_DISPATCHED;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_emit_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> state_reg == S_IDLE)
        else $error("result emitted but controller not back to idle");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN1 |-> !stat.empty)
        else $error("dispatch scan running on an empty table");

endmodule

// ===== rtl/npd_dpath.sv =====
// Datapath: job table, scan trackers, timing arithmetic, run totals and result registers.
module npd_dpath (
    input  logic           clk,
    input  logic           rst_n,
    input  npd_pkg::cmd_t  cmd,
    output npd_pkg::stat_t stat,
    input  logic [7:0]     job_priority,
    input  logic [15:0]    job_burst,
    input  logic [31:0]    job_arrival,
    output logic           done,
    output logic [1:0]     status,
    output logic [15:0]    job_number,
    output logic [31:0]    dispatch_time,
    output logic [31:0]    job_wait,
    output logic [31:0]    job_turnaround,
    output logic [47:0]    sum_wait,
    output logic [47:0]    sum_turnaround,
    output logic [15:0]    jobs_done,
    output logic           run_finished
);

    npd_pkg::slot_t     mem [npd_pkg::TABLE_SLOTS];
    npd_pkg::slot_t     rd_data_reg;
    logic               rd_live_reg;
    npd_pkg::slot_idx_t rd_idx_reg;

    logic [npd_pkg::TABLE_SLOTS-1:0] valid_reg;
    npd_pkg::age_t                   age_reg [npd_pkg::TABLE_SLOTS];
    npd_pkg::cnt_t                   count_reg;
    npd_pkg::id_t                    next_id_reg;
    npd_pkg::time_t                  clock_reg;
    npd_pkg::total_t                 wait_total_reg, turn_total_reg;
    npd_pkg::id_t                    done_count_reg;

    npd_pkg::prio_t  in_prio_reg;
    npd_pkg::burst_t in_burst_reg;
    npd_pkg::time_t  in_arr_reg;

    logic               any_reg, ready_reg, found_reg;
    npd_pkg::time_t     min_arr_reg;
    npd_pkg::prio_t     best_prio_reg;
    npd_pkg::age_t      best_age_reg;
    npd_pkg::burst_t    best_burst_reg;
    npd_pkg::time_t     best_arr_reg;
    npd_pkg::id_t       best_id_reg;
    npd_pkg::slot_idx_t sel_reg;

    npd_pkg::time_t start_reg, wait_reg, finish_reg, turn_reg;

    logic              done_reg;
    npd_pkg::status_t  out_status_reg;
    npd_pkg::id_t      out_number_reg, out_jobs_reg;
    npd_pkg::time_t    out_start_reg, out_wait_reg, out_turn_reg;
    npd_pkg::total_t   out_sumw_reg, out_sumt_reg;
    logic              out_fin_reg;

    logic                         rd_hit, cur_ready, cur_better, finishing;
    npd_pkg::age_t                cur_age;
    npd_pkg::tsum_t               finish_sum;
    logic [npd_pkg::TOTAL_BITS:0] wait_sum, turn_sum;

    assign stat.full      = (count_reg == npd_pkg::SCAN_END);
    assign stat.empty     = (count_reg == '0);
    assign stat.slot_free = !valid_reg[cmd.rd_addr];

    assign rd_hit     = rd_live_reg && valid_reg[rd_idx_reg];
    assign cur_age    = age_reg[rd_idx_reg];
    assign cur_ready  = (rd_data_reg.arrival <= clock_reg);
    assign cur_better = !found_reg || (rd_data_reg.prio > best_prio_reg) ||
                        ((rd_data_reg.prio == best_prio_reg) && (cur_age < best_age_reg));
    assign finishing  = (count_reg == npd_pkg::CNT_ONE);

    assign finish_sum = npd_pkg::tsum_t'(clock_reg) + npd_pkg::tsum_t'(best_burst_reg);
    assign wait_sum   = {1'b0, wait_total_reg} + (npd_pkg::TOTAL_BITS + 1)'(wait_reg);
    assign turn_sum   = {1'b0, turn_total_reg} + (npd_pkg::TOTAL_BITS + 1)'(turn_reg);

    // table storage
    always_ff @(posedge clk)
    begin
        if (cmd.sub_write)
            mem[cmd.rd_addr] <= '{prio: in_prio_reg, burst: in_burst_reg,
                                  arrival: in_arr_reg, id: next_id_reg};
        if (cmd.rd_en)
            rd_data_reg <= mem[cmd.rd_addr];
    end

    // age rank per slot, 0 is newest
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < npd_pkg::TABLE_SLOTS; i++)
        begin
            if (cmd.sub_write)
            begin
                if (npd_pkg::slot_idx_t'(i) == cmd.rd_addr)
                    age_reg[i] <= '0;
                else if (valid_reg[i])
                    age_reg[i] <= age_reg[i] + npd_pkg::age_t'(1);
            end
            else if (cmd.retire && valid_reg[i] && (age_reg[i] > best_age_reg))
            begin
                age_reg[i] <= age_reg[i] - npd_pkg::age_t'(1);
            end
        end
    end

    // input capture, trackers and arithmetic stages
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_prio_reg  <= npd_pkg::prio_t'(job_priority);
            in_burst_reg <= job_burst;
            in_arr_reg   <= npd_pkg::time_t'(job_arrival);
        end
        if (rd_hit && !cmd.pass2 && (!any_reg || (rd_data_reg.arrival < min_arr_reg)))
            min_arr_reg <= rd_data_reg.arrival;
        if (rd_hit && cmd.pass2 && cur_ready && cur_better)
        begin
            best_prio_reg  <= rd_data_reg.prio;
            best_age_reg   <= cur_age;
            best_burst_reg <= rd_data_reg.burst;
            best_arr_reg   <= rd_data_reg.arrival;
            best_id_reg    <= rd_data_reg.id;
            sel_reg        <= rd_idx_reg;
        end
        if (cmd.calc1)
        begin
            start_reg  <= clock_reg;
            wait_reg   <= clock_reg - best_arr_reg;
            finish_reg <= (finish_sum > npd_pkg::TIME_LIMIT) ? '1
                                                            : npd_pkg::time_t'(finish_sum);
        end
        if (cmd.calc2)
            turn_reg <= finish_reg - best_arr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_live_reg    <= 1'b0;
            rd_idx_reg     <= '0;
            valid_reg      <= '0;
            count_reg      <= '0;
            next_id_reg    <= '0;
            clock_reg      <= '0;
            wait_total_reg <= '0;
            turn_total_reg <= '0;
            done_count_reg <= '0;
            any_reg        <= 1'b0;
            ready_reg      <= 1'b0;
            found_reg      <= 1'b0;
        end
        else
        begin
            rd_live_reg <= cmd.rd_en;
            rd_idx_reg  <= cmd.rd_addr;
            if (cmd.sub_write)
            begin
                valid_reg[cmd.rd_addr] <= 1'b1;
                count_reg              <= count_reg + npd_pkg::CNT_ONE;
                next_id_reg            <= next_id_reg + npd_pkg::id_t'(1);
            end
            if (cmd.scan_clr)
            begin
                any_reg   <= 1'b0;
                ready_reg <= 1'b0;
            end
            else if (rd_hit && !cmd.pass2)
            begin
                any_reg <= 1'b1;
                if (cur_ready)
                    ready_reg <= 1'b1;
            end
            if (cmd.jump)
            begin
                found_reg <= 1'b0;
                if (!ready_reg)
                    clock_reg <= min_arr_reg;
            end
            else if (rd_hit && cmd.pass2 && cur_ready)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.calc2)
                wait_total_reg <= wait_sum[npd_pkg::TOTAL_BITS] ? '1
                                  : wait_sum[npd_pkg::TOTAL_BITS-1:0];
            if (cmd.calc3)
            begin
                turn_total_reg <= turn_sum[npd_pkg::TOTAL_BITS] ? '1
                                  : turn_sum[npd_pkg::TOTAL_BITS-1:0];
                if (done_count_reg != '1)
                    done_count_reg <= done_count_reg + npd_pkg::id_t'(1);
                clock_reg <= finish_reg;
            end
            if (cmd.retire)
            begin
                valid_reg[sel_reg] <= 1'b0;
                count_reg          <= count_reg - npd_pkg::CNT_ONE;
                if (finishing)
                begin
                    clock_reg      <= '0;
                    wait_total_reg <= '0;
                    turn_total_reg <= '0;
                    done_count_reg <= '0;
                end
            end
        end
    end

    // result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.emit;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_status_reg <= cmd.emit_status;
            case (cmd.emit_status)
                npd_pkg::ST_SUBMITTED:  out_number_reg <= next_id_reg;
                npd_pkg::ST_DISPATCHED: out_number_reg <= best_id_reg;
                default:                out_number_reg <= '0;
            endcase
            if (cmd.emit_status == npd_pkg::ST_DISPATCHED)
            begin
                out_start_reg <= start_reg;
                out_wait_reg  <= wait_reg;
                out_turn_reg  <= turn_reg;
                out_sumw_reg  <= wait_total_reg;
                out_sumt_reg  <= turn_total_reg;
                out_jobs_reg  <= done_count_reg;
                out_fin_reg   <= finishing;
            end
            else
            begin
                out_start_reg <= '0;
                out_wait_reg  <= '0;
                out_turn_reg  <= '0;
                out_sumw_reg  <= '0;
                out_sumt_reg  <= '0;
                out_jobs_reg  <= '0;
                out_fin_reg   <= 1'b0;
            end
        end
    end

    assign done           = done_reg;
    assign status         = out_status_reg;
    assign job_number     = out_number_reg;
    assign dispatch_time  = 32'(out_start_reg);
    assign job_wait       = 32'(out_wait_reg);
    assign job_turnaround = 32'(out_turn_reg);
    assign sum_wait       = out_sumw_reg;
    assign sum_turnaround = out_sumt_reg;
    assign jobs_done      = out_jobs_reg;
    assign run_finished   = out_fin_reg;

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == npd_pkg::cnt_t'($countones(valid_reg)))
        else $error("occupancy count out of step with valid bits");

    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sub_write |-> !valid_reg[cmd.rd_addr] && !stat.full)
        else $error("submit overwrites an occupied slot");

    a_retire_found: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.retire |-> found_reg && valid_reg[sel_reg])
        else $error("dispatch retires without a selected ready job");

endmodule
